/* design/pba_pkg.sv */
`timescale 1ns / 1ps

package pba_pkg;

  localparam int NumBuckets    = 11;
  localparam int NumChunks     = 64;
  localparam int MinBlockBytes = 16;
  localparam int ChunkBytes    = 1 << (NumBuckets + 2);
  localparam int SlotsPerChunk = ChunkBytes / MinBlockBytes;
  localparam int NumSlots      = NumChunks * SlotsPerChunk;
  localparam int SlotW         = $clog2(NumSlots);
  localparam int BucketW       = 4;
  localparam int ChunkCntW     = $clog2(NumChunks + 1);
  localparam int RemainW       = 10;
  localparam int AddrW         = 19;
  localparam int ReqW          = 20;
  localparam int OvhW          = 7;
  localparam int ShiftW        = $clog2(MinBlockBytes);

  localparam logic [OvhW-1:0] OverheadReset = OvhW'(14);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_MEMORY = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [SlotW-1:0]   slot;
  } link_t;

  typedef struct packed {
    logic               in_use;
    logic [BucketW-1:0] bucket;
  } tag_t;

  typedef struct packed {
    op_t                op;
    logic               too_large;
    logic               misaligned;
    logic [BucketW-1:0] bucket;
    logic [SlotW-1:0]   slot;
  } cmd_t;

endpackage

/* design/pba_front.sv */
`timescale 1ns / 1ps

module pba_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pba_pkg::OvhW-1:0]     cfg_overhead_bytes,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [pba_pkg::ReqW-1:0]     in_request_bytes,
  input  logic [pba_pkg::AddrW-1:0]    in_block_address,
  input  logic                         clearing,
  input  logic                         q_full,
  output logic                         q_push,
  output pba_pkg::cmd_t                q_cmd
);
  import pba_pkg::*;

  logic [OvhW-1:0]  overhead_r;
  logic [ReqW:0]    need;
  logic [BucketW-1:0] bkt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full | clearing;
  assign q_push    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhead_r <= OverheadReset;
    end else if (cfg_valid && cfg_ready) begin
      overhead_r <= cfg_overhead_bytes;
    end
  end

  assign need = {1'b0, in_request_bytes} + (ReqW + 1)'(overhead_r);

  always_comb begin
    bkt = BucketW'(1);
    for (int i = 1; i < NumBuckets - 1; i++) begin
      if (need > (ReqW + 1)'(MinBlockBytes << (i - 1))) begin
        bkt = BucketW'(i + 1);
      end
    end
  end

  always_comb begin
    q_cmd.op         = op_t'(in_op);
    q_cmd.too_large  = need >= (ReqW + 1)'(ChunkBytes);
    q_cmd.misaligned = in_block_address[ShiftW-1:0] != '0;
    q_cmd.bucket     = bkt;
    q_cmd.slot       = in_block_address[ShiftW +: SlotW];
  end

endmodule

/* design/pba_queue.sv */
`timescale 1ns / 1ps

module pba_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pba_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output pba_pkg::cmd_t   head_cmd
);
  import pba_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign head_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/pba_back.sv */
`timescale 1ns / 1ps

module pba_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  pba_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [pba_pkg::AddrW-1:0]     out_granted_address,
  output logic [pba_pkg::BucketW-1:0]   out_bucket_used
);
  import pba_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                 state_r;
  logic [SlotW:0]         clr_cnt_r;
  cmd_t                   cur_r;
  link_t                  link_rd_r;
  tag_t                   tag_rd_r;
  link_t                  link_mem [NumSlots];
  tag_t                   tag_mem  [NumSlots];

  link_t                  head_r   [NumBuckets];
  logic [SlotW-1:0]       pos_r    [NumBuckets];
  logic [RemainW-1:0]     rem_r    [NumBuckets];
  logic [ChunkCntW-1:0]   chunks_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [AddrW-1:0]       out_addr_r;
  logic [BucketW-1:0]     out_bkt_r;

  logic                   fire;
  status_t                st;
  logic [SlotW-1:0]       slot;
  logic [BucketW-1:0]     bkt;
  logic [SlotW-1:0]       step;
  logic                   do_pop_head, do_carve, do_claim, do_free;
  logic                   tag_we;
  logic [SlotW-1:0]       tag_wa;
  tag_t                   tag_wd;
  link_t                  head_sel;

  assign clearing  = state_r == S_CLEAR;
  assign q_pop     = state_r == S_IDLE && !q_empty;
  assign fire      = state_r == S_EXEC && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_bucket_used     = out_bkt_r;

  assign step = SlotW'(1) << (cur_r.bucket - BucketW'(1));

  always_comb begin
    st          = ST_OK;
    slot        = '0;
    bkt         = '0;
    do_pop_head = 1'b0;
    do_carve    = 1'b0;
    do_claim    = 1'b0;
    do_free     = 1'b0;
    head_sel    = '0;
    if (cur_r.op == OP_ALLOC) begin
      head_sel = head_r[cur_r.bucket];
      if (cur_r.too_large) begin
        st = ST_TOO_LARGE;
      end else begin
        bkt = cur_r.bucket;
        if (head_sel.valid) begin
          slot        = head_sel.slot;
          do_pop_head = 1'b1;
        end else if (rem_r[cur_r.bucket] != '0) begin
          slot     = pos_r[cur_r.bucket];
          do_carve = 1'b1;
        end else if (chunks_r < ChunkCntW'(NumChunks)) begin
          slot     = SlotW'(chunks_r) << $clog2(SlotsPerChunk);
          do_claim = 1'b1;
        end else begin
          st = ST_NO_MEMORY;
        end
      end
    end else begin
      if (cur_r.misaligned || !tag_rd_r.in_use ||
          tag_rd_r.bucket >= BucketW'(NumBuckets)) begin
        st = ST_BAD_FREE;
      end else begin
        bkt      = tag_rd_r.bucket;
        head_sel = head_r[tag_rd_r.bucket];
        do_free  = 1'b1;
      end
    end
  end

  always_comb begin
    tag_we = 1'b0;
    tag_wa = cur_r.slot;
    tag_wd = '0;
    if (state_r == S_CLEAR) begin
      tag_we = 1'b1;
      tag_wa = clr_cnt_r[SlotW-1:0];
    end else if (fire && (do_pop_head || do_carve || do_claim)) begin
      tag_we        = 1'b1;
      tag_wa        = slot;
      tag_wd.in_use = 1'b1;
      tag_wd.bucket = cur_r.bucket;
    end else if (fire && do_free) begin
      tag_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (q_pop) begin
      tag_rd_r <= tag_mem[q_cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_free) begin
      link_mem[cur_r.slot] <= head_sel;
    end
    if (q_pop) begin
      link_rd_r <= link_mem[head_r[q_cmd.bucket].slot];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (fire) begin
      out_status_r <= st;
      out_addr_r   <= (st == ST_OK && cur_r.op == OP_ALLOC) ?
                      AddrW'(slot) << ShiftW : '0;
      out_bkt_r    <= bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      chunks_r    <= '0;
      for (int i = 0; i < NumBuckets; i++) begin
        head_r[i] <= '0;
        pos_r[i]  <= '0;
        rem_r[i]  <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == (SlotW + 1)'(NumSlots - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (do_pop_head) begin
              head_r[cur_r.bucket] <= link_rd_r;
            end
            if (do_carve) begin
              pos_r[cur_r.bucket] <= slot + step;
              rem_r[cur_r.bucket] <= rem_r[cur_r.bucket] - 1'b1;
            end
            if (do_claim) begin
              chunks_r            <= chunks_r + 1'b1;
              pos_r[cur_r.bucket] <= slot + step;
              rem_r[cur_r.bucket] <=
                (RemainW'(1) << (BucketW'(NumBuckets - 1) - cur_r.bucket)) - 1'b1;
            end
            if (do_free) begin
              head_r[bkt] <= '{valid: 1'b1, slot: cur_r.slot};
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/power_of_two_bucket_allocator_top.sv */
`timescale 1ns / 1ps

// heap allocator with ten power-of-two buckets of 16 to 8192 bytes over a
// 512 KiB pool of 64 chunks; allocate takes request plus overhead, free takes
// a block address, each item gives one result; after reset the tag memory is
// swept over all 32768 slots with the input stalled; in the back end an item
// then goes through a registered tag and link memory read and then a bucket
// state update held by out_stall; a two-entry queue sits behind the front end
module power_of_two_bucket_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pba_pkg::OvhW-1:0]      cfg_overhead_bytes,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [pba_pkg::ReqW-1:0]      in_request_bytes,
  input  logic [pba_pkg::AddrW-1:0]     in_block_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [pba_pkg::AddrW-1:0]     out_granted_address,
  output logic [pba_pkg::BucketW-1:0]   out_bucket_used
);
  import pba_pkg::*;

  logic   q_push;
  logic   q_full;
  cmd_t   push_cmd;
  cmd_t   head_cmd;
  logic   q_empty;
  logic   q_pop;
  logic   clearing;

  pba_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_overhead_bytes (cfg_overhead_bytes),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_request_bytes   (in_request_bytes),
    .in_block_address   (in_block_address),
    .clearing           (clearing),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (push_cmd)
  );

  pba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  pba_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_cmd               (head_cmd),
    .q_pop               (q_pop),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_bucket_used     (out_bucket_used)
  );

endmodule
